>>> rtl/ssd_pkg.sv
package ssd_pkg;

	// Address register width of the command set
	localparam int ADDR_W = 24;

	// Command bytes
	localparam logic [7:0] CMD_WRMR = 8'h01;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_READ = 8'h03;
	localparam logic [7:0] CMD_RDMR = 8'h05;

	// Byte presented when nothing is driven
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	// Mode register values
	localparam logic [1:0] MODE_BYTE = 2'd0;
	localparam logic [1:0] MODE_SEQ = 2'd1;
	localparam logic [1:0] MODE_PAGE = 2'd2;

	// Transaction phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_RADDR = 3'd1;
	localparam logic [2:0] PH_RDATA = 3'd2;
	localparam logic [2:0] PH_WADDR = 3'd3;
	localparam logic [2:0] PH_WDATA = 3'd4;
	localparam logic [2:0] PH_RMODE = 3'd5;
	localparam logic [2:0] PH_WMODE = 3'd6;
	localparam logic [2:0] PH_SINK = 3'd7;

	// One access to the byte array
	typedef struct packed {
		logic wr;
		logic rd;
		logic [ADDR_W-1:0] addr;
		logic [7:0] wdata;
	} mem_req_t;

endpackage

>>> rtl/ssd_mem.sv
module ssd_mem #(
	parameter int AW = 17
) (
	input logic clk,
	input logic arst_n,
	input ssd_pkg::mem_req_t req,
	output logic [7:0] rdata,
	output logic busy
);
	import ssd_pkg::*;

	logic [7:0] mem [0:(1 << AW)-1];
	logic [AW-1:0] clr_addr_q;
	logic busy_q;
	logic [7:0] rdata_q;

	// Sweep zeros through the array after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == {AW{1'b1}}) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Write port: clearing pass or request
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (req.wr) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
	end

	// Registered read port; hold data until the next read
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;
	assign busy = busy_q;

endmodule

>>> rtl/spi_sram_device.sv
// Serial SRAM device behind a byte-level SPI view. Each request is either one byte
// shifted in on MOSI or a chip-select change; each yields one result, the byte the
// device shifts out on the next transfer. Commands: write mode (0x01), write (0x02),
// read (0x03), read mode (0x05); other commands sink the transaction. The byte array
// sits in one synchronous RAM of 65536 << MAX_BANKS_LOG2 bytes. A request is accepted
// at a clock edge, where the RAM read data and stage 1 are registered; the output
// register is loaded from them once it is free and offers the result. With the result
// side ready a new request is taken every cycle. After reset the RAM is cleared one
// byte per cycle while item_ready stays low. The configuration register is written
// at any edge where cfg_we is high; change it only while no request is in flight.
module spi_sram_device #(
	parameter int MAX_BANKS_LOG2 = 1,
	parameter int PAGE_BYTES = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_data,
	input logic item_valid,
	output logic item_ready,
	input logic req_type,
	input logic [7:0] mosi_byte,
	input logic cs_active,
	output logic result_valid,
	input logic result_ready,
	output logic [7:0] miso_byte
);
	import ssd_pkg::*;

	localparam int MEM_AW = 16 + MAX_BANKS_LOG2;
	localparam logic HAS_BANKS = (MAX_BANKS_LOG2 > 0);
	localparam logic [ADDR_W-1:0] PAGE_LOW = ADDR_W'(PAGE_BYTES - 1);

	// Architectural state
	logic bank_q;
	logic [2:0] phase_q;
	logic [1:0] pos_q;
	logic [ADDR_W-1:0] addr_q;
	logic [1:0] mode_q;
	logic sel_q;

	// Stage 1 and output register
	logic v_s1;
	logic rd_s1;
	logic keep_s1;
	logic [7:0] byte_s1;
	logic result_valid_q;
	logic [7:0] miso_q;

	logic acc;
	logic s1_move;
	logic busy;
	logic [7:0] rdata;
	mem_req_t req;

	// Next-state values
	logic [2:0] n_phase;
	logic [1:0] n_pos;
	logic [ADDR_W-1:0] n_addr;
	logic [1:0] n_mode;
	logic n_sel;
	logic rd_c;
	logic wr_c;
	logic keep_c;
	logic [7:0] obyte_c;
	logic [ADDR_W-1:0] maddr_c;

	// Address helpers
	logic lg_eff;
	logic [ADDR_W-1:0] mask24;
	logic [ADDR_W-1:0] inc;
	logic [ADDR_W-1:0] page_next;
	logic [ADDR_W-1:0] adv_rd;
	logic [ADDR_W-1:0] adv_wr;
	logic [1:0] alen;
	logic [1:0] sh;
	logic [1:0] pos_inc;
	logic merge;
	logic done;
	logic [ADDR_W-1:0] shifted;
	logic [ADDR_W-1:0] addr_merged;

	assign s1_move = v_s1 && (!result_valid_q || result_ready);
	assign item_ready = !busy && (!v_s1 || s1_move);
	assign acc = item_valid && item_ready;

	// Address mask and advance
	assign lg_eff = HAS_BANKS & bank_q;
	assign mask24 = {7'd0, lg_eff, 16'hFFFF};
	assign inc = addr_q + ADDR_W'(1);
	assign page_next = (addr_q & ~PAGE_LOW) | (inc & PAGE_LOW);

	always_comb begin
		unique case (mode_q)
			MODE_PAGE: begin
				adv_rd = page_next;
				adv_wr = page_next;
			end
			MODE_SEQ: begin
				adv_rd = inc;
				adv_wr = inc & mask24;
			end
			default: begin
				adv_rd = addr_q;
				adv_wr = addr_q;
			end
		endcase
	end

	// Merge one big-endian address byte
	assign alen = lg_eff ? 2'd3 : 2'd2;
	assign merge = pos_q < alen;
	assign sh = alen - 2'd1 - pos_q;
	assign pos_inc = pos_q + 2'd1;
	assign done = pos_inc >= alen;

	always_comb begin
		unique case (sh)
			2'd0: shifted = {16'd0, mosi_byte};
			2'd1: shifted = {8'd0, mosi_byte, 8'd0};
			2'd2: shifted = {mosi_byte, 16'd0};
			default: shifted = '0;
		endcase
	end

	assign addr_merged = merge ? (addr_q | shifted) : addr_q;

	// Decode one request
	always_comb begin
		n_phase = phase_q;
		n_pos = pos_q;
		n_addr = addr_q;
		n_mode = mode_q;
		n_sel = sel_q;
		rd_c = 1'b0;
		wr_c = 1'b0;
		keep_c = 1'b0;
		obyte_c = IDLE_BYTE;
		maddr_c = addr_q & mask24;
		if (req_type) begin
			keep_c = 1'b1;
			if (cs_active != sel_q) begin
				n_sel = cs_active;
				if (!cs_active) begin
					n_phase = PH_IDLE;
					n_pos = 2'd0;
				end
			end
		end else if (phase_q == PH_RDATA) begin
			n_addr = adv_rd;
			rd_c = 1'b1;
			maddr_c = adv_rd & mask24;
		end else if (sel_q) begin
			unique case (phase_q)
				PH_IDLE: begin
					n_pos = 2'd0;
					priority if (mosi_byte == CMD_WRMR) begin
						n_phase = PH_WMODE;
					end else if (mosi_byte == CMD_WRITE) begin
						n_phase = PH_WADDR;
						n_addr = '0;
					end else if (mosi_byte == CMD_READ) begin
						n_phase = PH_RADDR;
						n_addr = '0;
					end else if (mosi_byte == CMD_RDMR) begin
						n_phase = PH_RMODE;
						obyte_c = {mode_q, 6'd0};
					end else begin
						n_phase = PH_SINK;
					end
				end
				PH_RADDR: begin
					n_addr = addr_merged;
					if (done) begin
						n_pos = 2'd0;
						n_phase = PH_RDATA;
						rd_c = 1'b1;
						maddr_c = addr_merged & mask24;
					end else begin
						n_pos = pos_inc;
					end
				end
				PH_WADDR: begin
					n_addr = addr_merged;
					if (done) begin
						n_pos = 2'd0;
						n_phase = PH_WDATA;
					end else begin
						n_pos = pos_inc;
					end
				end
				PH_WDATA: begin
					wr_c = 1'b1;
					n_addr = adv_wr;
				end
				PH_RMODE: begin
					n_phase = PH_SINK;
				end
				PH_WMODE: begin
					n_mode = mosi_byte[7:6];
					n_phase = PH_SINK;
				end
				default: begin
				end
			endcase
		end
	end

	// Issue the RAM access with the request
	always_comb begin
		req.wr = acc && wr_c;
		req.rd = acc && rd_c;
		req.addr = maddr_c;
		req.wdata = mosi_byte;
	end

	ssd_mem #(
		.AW(MEM_AW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rdata(rdata),
		.busy(busy)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b1;
		end else if (cfg_we) begin
			bank_q <= cfg_data;
		end
	end

	// Advance device state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= 2'd0;
			addr_q <= '0;
			mode_q <= MODE_SEQ;
			sel_q <= 1'b0;
		end else if (acc) begin
			phase_q <= n_phase;
			pos_q <= n_pos;
			addr_q <= n_addr;
			mode_q <= n_mode;
			sel_q <= n_sel;
		end
	end

	// Stage 1: wait for RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= rd_c;
			keep_s1 <= keep_c;
			byte_s1 <= obyte_c;
		end
	end

	// Output register; it also holds the byte the device presents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			miso_q <= IDLE_BYTE;
		end else if (s1_move) begin
			result_valid_q <= 1'b1;
			if (!keep_s1) begin
				miso_q <= rd_s1 ? rdata : byte_s1;
			end
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign miso_byte = miso_q;

	// Checks
	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted request did not reach stage 1");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("address byte position out of range");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr && req.rd))
		else $error("read and write issued together");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(req.wr || req.rd))
		else $error("RAM access during clearing pass");

	a_deselect_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type && !cs_active) |=> (phase_q == PH_IDLE && pos_q == 2'd0))
		else $error("deselect did not return to idle");

endmodule
